FILE: hw/rtl/bmorph_pkg.sv
// Shared types and constants for the 3x3 binary morphology stream.
// No dependencies; imported by bmorph_win_cell and the top level.
package bmorph_pkg;

  // Default line store depth (pixels per line)
  localparam int unsigned MaxLineWidth = 1024;

  // Register field widths
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 12;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned CfgIdxW    = 2;

  // Position counters
  localparam int unsigned RowW  = 12;
  localparam int unsigned ItemW = 24;
  localparam logic [RowW-1:0]  RowMax  = {RowW{1'b1}};
  localparam logic [ItemW-1:0] ItemMax = {ItemW{1'b1}};

  // Smallest width / height that the block works with
  localparam int unsigned MinDim = 3;

  // Reset values of the registers
  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 12'd480;

  // Stream payload layout
  localparam int unsigned TDataW          = 8;
  localparam int unsigned TUserW          = 2;
  localparam int unsigned TuserFrameStart = 0;
  localparam int unsigned TuserPadding    = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_OPERATION_MODE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_ERODE  = 1'b0,
    OP_DILATE = 1'b1
  } op_mode_e;

  // One window column: [2] upper line, [1] middle line, [0] newest line
  typedef logic [2:0] win_col_t;

  // Running AND / OR over the window, passed along the cell chain
  typedef struct packed {
    logic all_set;
    logic any_set;
  } win_red_t;

endpackage

FILE: hw/rtl/bmorph_line_store.sv
// Two-line pixel store: {upper, middle} bit per column, one write and one read port.
// Depends on nothing; the read port forwards a same-cycle write to the same column.
module bmorph_line_store #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [1:0]               wr_data_i,
  output logic [1:0]               rd_data_o
);

  logic [1:0] mem_q [DEPTH];
  logic [1:0] rd_q;
  logic       byp_q;
  logic [1:0] byp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      byp_data_q <= wr_data_i;
    end
  end

  // read-during-write: take the new data
  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

FILE: hw/rtl/bmorph_win_cell.sv
// One column cell of the 3x3 window: holds a column, shifts on enable,
// extends the running AND/OR chain. Depends on bmorph_pkg.
module bmorph_win_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  bmorph_pkg::win_col_t col_i,
  input  bmorph_pkg::win_red_t red_i,
  output bmorph_pkg::win_col_t col_o,
  output bmorph_pkg::win_red_t red_o
);
  import bmorph_pkg::*;

  win_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o         = col_q;
  assign red_o.all_set = red_i.all_set & (&col_q);
  assign red_o.any_set = red_i.any_set | (|col_q);

endmodule

FILE: hw/rtl/binary_morphology_3x3_stream.sv
// Top level of the streaming 3x3 binary erosion / dilation block.
// Depends on bmorph_pkg, bmorph_line_store and bmorph_win_cell.
//
// Channel    Dir  Handshake                     Payload
// s_axis     in   s_axis_tvalid/s_axis_tready   tdata[0] pixel_in; tuser[0] frame_start,
//                                               tuser[1] padding
// m_axis     out  m_axis_tvalid/m_axis_tready   tdata[0] pixel_out; tlast frame_last
// cfg        in   cfg_we_i (no wait)            cfg_index_i, cfg_data_i
//
// One request per clock sustained while the output is taken. A request is read out of the line
// store in its accept cycle; when it leaves the window stage it shifts the window cells and
// its result is loaded into the output register in the same cycle.
// The result for pixel n shows up with request n + width + 1 of the frame.
// s_axis_tready drops only while the output register is full and not taken.
// Line stores come out of reset unwritten; no clearing pass.
module binary_morphology_3x3_stream #(
  parameter int unsigned MAX_LINE_WIDTH = bmorph_pkg::MaxLineWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bmorph_pkg::TDataW-1:0]     s_axis_tdata,  // [0] pixel_in
  input  logic [bmorph_pkg::TUserW-1:0]     s_axis_tuser,  // [0] frame_start, [1] padding
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bmorph_pkg::TDataW-1:0]     m_axis_tdata,  // [0] pixel_out
  output logic                              m_axis_tlast,  // frame_last
  // configuration
  input  logic                              cfg_we_i,
  input  logic [bmorph_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bmorph_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bmorph_pkg::*;

  localparam int unsigned ColW   = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WW     = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned EW     = (WW > WidthRegW) ? WW : WidthRegW;
  localparam int unsigned ProdW  = WW + RowW;
  localparam int unsigned BoundW = ProdW + 1;
  localparam int unsigned CmpW   = (BoundW > ItemW + 1) ? BoundW : ItemW + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WidthRegW-1:0]  cfg_width_q;
  logic [HeightRegW-1:0] cfg_height_q;
  op_mode_e              cfg_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthReset;
      cfg_height_q <= HeightReset;
      cfg_mode_q   <= OP_ERODE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:    cfg_width_q  <= cfg_data_i[WidthRegW-1:0];
        REG_FRAME_HEIGHT:   cfg_height_q <= cfg_data_i[HeightRegW-1:0];
        REG_OPERATION_MODE: cfg_mode_q   <= op_mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // Clamped frame size
  logic [WW-1:0]   eff_w;
  logic [RowW-1:0] eff_h;

  always_comb begin
    if (EW'(cfg_width_q) > EW'(MAX_LINE_WIDTH)) begin
      eff_w = WW'(MAX_LINE_WIDTH);
    end else if (cfg_width_q < WidthRegW'(MinDim)) begin
      eff_w = WW'(MinDim);
    end else begin
      eff_w = WW'(cfg_width_q);
    end
    eff_h = (cfg_height_q < RowW'(MinDim)) ? RowW'(MinDim) : cfg_height_q;
  end

  // Pixels per frame, registered from the clamped frame size
  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(eff_w) * ProdW'(eff_h);
  end

  // ---------------------------------------------------------------------------
  // Accept stage: position counters and line store read
  // ---------------------------------------------------------------------------
  logic             in_fire;
  logic             in_fs;
  logic             in_px;
  logic [ColW-1:0]  col_q, col_d, cur_col;
  logic [RowW-1:0]  row_q, row_d, cur_row;
  logic [ItemW-1:0] items_q, items_d, cur_n;
  logic             wrap;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_fs   = s_axis_tuser[TuserFrameStart];
  // padding carries a clear pixel
  assign in_px   = s_axis_tuser[TuserPadding] ? 1'b0 : s_axis_tdata[0];

  always_comb begin
    cur_col = in_fs ? '0 : col_q;
    cur_row = in_fs ? '0 : row_q;
    cur_n   = in_fs ? '0 : items_q;
    wrap    = (WW'(cur_col) + WW'(1)) >= eff_w;
    if (wrap) begin
      col_d = '0;
      row_d = (cur_row == RowMax) ? cur_row : cur_row + RowW'(1);
    end else begin
      col_d = cur_col + ColW'(1);
      row_d = cur_row;
    end
    items_d = (cur_n == ItemMax) ? cur_n : cur_n + ItemW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      items_q <= '0;
    end else if (in_fire) begin
      col_q   <= col_d;
      row_q   <= row_d;
      items_q <= items_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Window stage
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic             s1_fire;
  logic [ColW-1:0]  s1_col_q;
  logic [RowW-1:0]  s1_row_q;
  logic [ItemW-1:0] s1_n_q;
  logic             s1_px_q;
  logic             m_valid_q;
  logic             m_pixel_q;
  logic             m_last_q;

  assign s1_fire       = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q <= cur_col;
      s1_row_q <= cur_row;
      s1_n_q   <= cur_n;
      s1_px_q  <= in_px;
    end
  end

  // rd_data: [1] upper line, [0] middle line; middle moves up on write
  logic [1:0] ls_rd;

  bmorph_line_store #(
    .DEPTH(MAX_LINE_WIDTH)
  ) u_line_store (
    .clk_i    (clk_i),
    .rd_en_i  (in_fire),
    .rd_addr_i(cur_col),
    .wr_en_i  (s1_fire),
    .wr_addr_i(s1_col_q),
    .wr_data_i({ls_rd[0], s1_px_q}),
    .rd_data_o(ls_rd)
  );

  // Cell chain: right column cell, then center column cell.
  // Reductions cover the window after the shift: new, right and center columns.
  win_col_t new_col;
  win_col_t right_col;
  win_col_t right_to_center;
  win_red_t red_new, red_right, red_all;

  assign new_col         = {ls_rd[1], ls_rd[0], s1_px_q};
  assign red_new.all_set = &new_col;
  assign red_new.any_set = |new_col;
  assign right_to_center = right_col;

  bmorph_win_cell u_cell_right (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (s1_fire),
    .col_i (new_col),
    .red_i (red_new),
    .col_o (right_col),
    .red_o (red_right)
  );

  bmorph_win_cell u_cell_center (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (s1_fire),
    .col_i (right_to_center),
    .red_i (red_right),
    .col_o (),
    .red_o (red_all)
  );

  // Result pixel. The pixel that lands in the center after the shift is the
  // middle bit of the right cell now; it also serves the row-wrap case.
  logic            border;
  logic            res_px;
  logic [CmpW-1:0] n_ext, lo_bound, hi_bound;
  logic            emit;
  logic            last;

  always_comb begin
    border = (s1_col_q == '0) || (s1_col_q == ColW'(1)) ||
             (WW'(s1_col_q) >= eff_w) ||
             (s1_row_q <= RowW'(1)) || (s1_row_q >= eff_h);
    if (border) begin
      res_px = right_col[1];
    end else begin
      res_px = (cfg_mode_q == OP_DILATE) ? red_all.any_set : red_all.all_set;
    end
    // emit for frame items width+1 .. width*height+width
    n_ext    = CmpW'(s1_n_q);
    lo_bound = CmpW'(eff_w) + CmpW'(1);
    hi_bound = CmpW'(prod_q) + CmpW'(eff_w);
    emit     = (n_ext >= lo_bound) && (n_ext <= hi_bound);
    last     = (n_ext == hi_bound);
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_fire) begin
      m_valid_q <= emit;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      m_pixel_q <= res_px;
      m_last_q  <= last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDataW'(m_pixel_q);
  assign m_axis_tlast  = m_last_q;

endmodule
